### hdl/lpde_pkg.sv
package lpde_pkg;

   localparam int MAX_DEGREE  = 15;
   localparam int DEG_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int X_W         = 32;
   localparam int VAL_W       = 48;
   localparam int NUM_W       = 54;
   localparam int SCL_W       = NUM_W + 1;
   localparam int COEF_W      = 6;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 3 * MUL_W;
   localparam int RECIP_W     = 41;
   localparam int XP_SHIFT    = 30;
   localparam int RECIP_SHIFT = 40;

   localparam logic [DEG_W-1:0] MAX_DEG_CODE = DEG_W'(MAX_DEGREE);
   localparam logic [VAL_W-1:0] ONE_VALUE    = {{(VAL_W-33){1'b0}}, 1'b1, 32'h0000_0000};
   localparam logic [VAL_W-1:0] SAT_POS      = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] SAT_NEG      = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [ACC_W:0]   ROUND_ONE    = {{ACC_W{1'b0}}, 1'b1};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_DEGREE  = 1'b0,
      CSR_HIGH_DEGREE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XP0,
      ST_XP1,
      ST_XPW,
      ST_XPR,
      ST_NUM,
      ST_NMAG,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_PW,
      ST_PR
   } state_type;

   typedef enum logic [1:0] {
      SHIFT_0,
      SHIFT_32,
      SHIFT_64
   } mac_shift_type;

   typedef struct packed {
      logic          issue;
      logic          clear;
      mac_shift_type shift;
   } mac_ctrl_type;

   // round(2^40 / j) in Q1.40
   function automatic logic [RECIP_W-1:0] recip_value(input logic [DEG_W-1:0] j);
      logic [RECIP_W-1:0] r;
      unique case (j)
         4'd1:    r = 41'd1099511627776;
         4'd2:    r = 41'd549755813888;
         4'd3:    r = 41'd366503875925;
         4'd4:    r = 41'd274877906944;
         4'd5:    r = 41'd219902325555;
         4'd6:    r = 41'd183251937963;
         4'd7:    r = 41'd157073089682;
         4'd8:    r = 41'd137438953472;
         4'd9:    r = 41'd122167958642;
         4'd10:   r = 41'd109951162778;
         4'd11:   r = 41'd99955602525;
         4'd12:   r = 41'd91625968981;
         4'd13:   r = 41'd84577817521;
         4'd14:   r = 41'd78536544841;
         4'd15:   r = 41'd73300775185;
         default: r = '0;
      endcase
      return r;
   endfunction

   // clamp a scaler sum to the 48-bit range
   function automatic logic [VAL_W-1:0] sat_value(input logic [SCL_W-1:0] s);
      logic [VAL_W-1:0] r;
      if ((&s[SCL_W-1:VAL_W-1]) || !(|s[SCL_W-1:VAL_W-1])) begin
         r = s[VAL_W-1:0];
      end else if (s[SCL_W-1]) begin
         r = SAT_NEG;
      end else begin
         r = SAT_POS;
      end
      return r;
   endfunction

   // magnitude product shifted right, round half up on magnitude, clamped
   function automatic logic [VAL_W-1:0] round_mag(input logic [ACC_W-1:0] acc,
                                                  input int sh, input logic neg);
      logic [ACC_W:0] sum;
      logic [ACC_W:0] q;
      logic [ACC_W:0] lim;
      sum = {1'b0, acc} + (ROUND_ONE << (sh - 1));
      q   = sum >> sh;
      lim = {{(ACC_W+1-VAL_W){1'b0}}, (neg ? SAT_NEG : SAT_POS)};
      return (q > lim) ? lim[VAL_W-1:0] : q[VAL_W-1:0];
   endfunction

endpackage

### hdl/lpde_scale.sv
module lpde_scale (
   input  logic signed [lpde_pkg::NUM_W-1:0]  base,
   input  logic signed [lpde_pkg::COEF_W-1:0] coef,
   input  logic signed [lpde_pkg::VAL_W-1:0]  operand,
   output logic signed [lpde_pkg::SCL_W-1:0]  sum
);

   logic signed [lpde_pkg::NUM_W-1:0] coef_ext;
   logic signed [lpde_pkg::NUM_W-1:0] operand_ext;
   logic signed [lpde_pkg::NUM_W-1:0] prod;

   // small coefficient times a recurrence value, plus a base term
   assign coef_ext    = {{(lpde_pkg::NUM_W-lpde_pkg::COEF_W){coef[lpde_pkg::COEF_W-1]}}, coef};
   assign operand_ext = {{(lpde_pkg::NUM_W-lpde_pkg::VAL_W){operand[lpde_pkg::VAL_W-1]}},
                         operand};
   assign prod        = coef_ext * operand_ext;
   assign sum         = {base[lpde_pkg::NUM_W-1], base} + {prod[lpde_pkg::NUM_W-1], prod};

endmodule

### hdl/lpde_mac.sv
module lpde_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  lpde_pkg::mac_ctrl_type      ctrl,
   input  logic [lpde_pkg::MUL_W-1:0]  opa,
   input  logic [lpde_pkg::MUL_W-1:0]  opb,
   output logic [lpde_pkg::ACC_W-1:0]  acc
);

   lpde_pkg::mac_ctrl_type            ctrl_ff;
   logic [lpde_pkg::PROD_W-1:0]       prod_ff;
   logic [lpde_pkg::PROD_W-1:0]       prod_in;
   logic [lpde_pkg::ACC_W-1:0]        acc_ff;
   logic [lpde_pkg::ACC_W-1:0]        acc_in;
   logic [lpde_pkg::ACC_W-1:0]        addend;

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // place the partial product at its 32-bit column
   always_comb begin
      unique case (ctrl_ff.shift)
         lpde_pkg::SHIFT_0:  addend = {{(lpde_pkg::ACC_W-lpde_pkg::PROD_W){1'b0}}, prod_ff};
         lpde_pkg::SHIFT_32: addend = {prod_ff, {lpde_pkg::MUL_W{1'b0}}};
         lpde_pkg::SHIFT_64: addend = {prod_ff[lpde_pkg::MUL_W-1:0], {lpde_pkg::PROD_W{1'b0}}};
         default:            addend = '0;
      endcase
      acc_in = acc_ff;
      if (ctrl_ff.issue) begin
         acc_in = (ctrl_ff.clear ? '0 : acc_ff) + addend;
      end
   end

   assign acc = acc_ff;

endmodule

### hdl/legendre_poly_deriv_eval.sv
// degree 0 result is on the rsp_ ports in the cycle after the accepting edge; each higher degree
//   takes one pass of the shared multiplier through XP0, XP1, XPW, XPR, NUM, NMAG, P0-P3, PW, PR
// busy stays high from the accepting edge until the top degree is emitted (never for an empty range);
//   a new start is taken only when busy is low, so a point is not accepted while one is in flight
// reset: synchronous active high; clears the sequencer and the strobe, low 0, high 15
// results are single-cycle strobes and cannot be stalled by the receiver
module legendre_poly_deriv_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [lpde_pkg::X_W-1:0]     req_x_value,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   output logic [lpde_pkg::DEG_W-1:0]          rsp_degree_out,
   output logic signed [lpde_pkg::VAL_W-1:0]   rsp_poly_value,
   output logic signed [lpde_pkg::VAL_W-1:0]   rsp_first_deriv,
   output logic signed [lpde_pkg::VAL_W-1:0]   rsp_second_deriv,
   output logic                                rsp_last_of_run,
   output logic                                rsp_batch_end,
   input  logic                                csr_write_enable,
   input  logic [lpde_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpde_pkg::DEG_W-1:0]          csr_write_data
);

   // sequencer and configuration
   lpde_pkg::state_type                state_ff, state_in;
   logic [lpde_pkg::DEG_W-1:0]         low_degree_ff, low_degree_in;
   logic [lpde_pkg::DEG_W-1:0]         high_degree_ff, high_degree_in;
   logic [lpde_pkg::DEG_W-1:0]         j_ff, j_in;
   logic [lpde_pkg::DEG_W-1:0]         hi_eff;

   // point being evaluated
   logic                               batch_ff, batch_in;
   logic [lpde_pkg::X_W-1:0]           x_mag_ff, x_mag_in;
   logic                               x_neg_ff, x_neg_in;

   // recurrence state, Q16.32
   logic signed [lpde_pkg::VAL_W-1:0]  pm1_ff, pm1_in;
   logic [lpde_pkg::VAL_W-1:0]         pm1_mag_ff, pm1_mag_in;
   logic                               pm1_neg_ff, pm1_neg_in;
   logic signed [lpde_pkg::VAL_W-1:0]  pm2_ff, pm2_in;
   logic signed [lpde_pkg::VAL_W-1:0]  pd1_ff, pd1_in;
   logic signed [lpde_pkg::VAL_W-1:0]  pd2_ff, pd2_in;
   logic signed [lpde_pkg::VAL_W-1:0]  pdd1_ff, pdd1_in;
   logic signed [lpde_pkg::VAL_W-1:0]  pdd2_ff, pdd2_in;

   // per-degree intermediates
   logic signed [lpde_pkg::VAL_W-1:0]  d_ff, d_in;
   logic signed [lpde_pkg::VAL_W-1:0]  dd_ff, dd_in;
   logic signed [lpde_pkg::VAL_W-1:0]  xp_ff, xp_in;
   logic signed [lpde_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [lpde_pkg::NUM_W-1:0]         nmag_ff, nmag_in;
   logic                               nneg_ff, nneg_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lpde_pkg::DEG_W-1:0]         rsp_degree_ff, rsp_degree_in;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_poly_ff, rsp_poly_in;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_d_ff, rsp_d_in;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_dd_ff, rsp_dd_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_batch_ff, rsp_batch_in;

   // shared multiplier and scaler hookup
   lpde_pkg::mac_ctrl_type             mac_ctrl;
   logic [lpde_pkg::MUL_W-1:0]         mac_a;
   logic [lpde_pkg::MUL_W-1:0]         mac_b;
   logic [lpde_pkg::ACC_W-1:0]         mac_acc;
   logic signed [lpde_pkg::NUM_W-1:0]  scl_base;
   logic signed [lpde_pkg::COEF_W-1:0] scl_coef;
   logic signed [lpde_pkg::VAL_W-1:0]  scl_operand;
   logic signed [lpde_pkg::SCL_W-1:0]  scl_sum;

   logic signed [lpde_pkg::COEF_W-1:0] coef_c;
   logic signed [lpde_pkg::COEF_W-1:0] coef_m;
   logic [lpde_pkg::RECIP_W-1:0]       recip;
   logic                               xp_neg;
   logic [lpde_pkg::VAL_W-1:0]         xp_mag;
   logic [lpde_pkg::VAL_W-1:0]         p_mag;
   logic signed [lpde_pkg::VAL_W-1:0]  p_val;
   logic                               accept;

   // the upper end of the degree range never exceeds the table size
   assign hi_eff = (high_degree_ff > lpde_pkg::MAX_DEG_CODE) ? lpde_pkg::MAX_DEG_CODE
                                                             : high_degree_ff;

   // 2j-1 and -(j-1) as small signed coefficients
   assign coef_c = {1'b0, j_ff, 1'b0} - {{(lpde_pkg::COEF_W-1){1'b0}}, 1'b1};
   assign coef_m = {{(lpde_pkg::COEF_W-1){1'b0}}, 1'b1} - {2'b00, j_ff};
   assign recip  = lpde_pkg::recip_value(j_ff);

   // rounding back ends of the two long products
   assign xp_neg = x_neg_ff ^ pm1_neg_ff;
   assign xp_mag = lpde_pkg::round_mag(mac_acc, lpde_pkg::XP_SHIFT, xp_neg);
   assign p_mag  = lpde_pkg::round_mag(mac_acc, lpde_pkg::RECIP_SHIFT, nneg_ff);
   assign p_val  = nneg_ff ? -p_mag : p_mag;

   assign accept = start && (state_ff == lpde_pkg::ST_IDLE);

   lpde_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .opa   (mac_a),
      .opb   (mac_b),
      .acc   (mac_acc)
   );

   lpde_scale u_scale (
      .base    (scl_base),
      .coef    (scl_coef),
      .operand (scl_operand),
      .sum     (scl_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lpde_pkg::ST_IDLE;
         low_degree_ff  <= '0;
         high_degree_ff <= lpde_pkg::MAX_DEG_CODE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         low_degree_ff  <= low_degree_in;
         high_degree_ff <= high_degree_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      j_ff          <= j_in;
      batch_ff      <= batch_in;
      x_mag_ff      <= x_mag_in;
      x_neg_ff      <= x_neg_in;
      pm1_ff        <= pm1_in;
      pm1_mag_ff    <= pm1_mag_in;
      pm1_neg_ff    <= pm1_neg_in;
      pm2_ff        <= pm2_in;
      pd1_ff        <= pd1_in;
      pd2_ff        <= pd2_in;
      pdd1_ff       <= pdd1_in;
      pdd2_ff       <= pdd2_in;
      d_ff          <= d_in;
      dd_ff         <= dd_in;
      xp_ff         <= xp_in;
      num_ff        <= num_in;
      nmag_ff       <= nmag_in;
      nneg_ff       <= nneg_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_poly_ff   <= rsp_poly_in;
      rsp_d_ff      <= rsp_d_in;
      rsp_dd_ff     <= rsp_dd_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_batch_ff  <= rsp_batch_in;
   end

   always_comb begin
      state_in       = state_ff;
      low_degree_in  = low_degree_ff;
      high_degree_in = high_degree_ff;
      j_in           = j_ff;
      batch_in       = batch_ff;
      x_mag_in       = x_mag_ff;
      x_neg_in       = x_neg_ff;
      pm1_in         = pm1_ff;
      pm1_mag_in     = pm1_mag_ff;
      pm1_neg_in     = pm1_neg_ff;
      pm2_in         = pm2_ff;
      pd1_in         = pd1_ff;
      pd2_in         = pd2_ff;
      pdd1_in        = pdd1_ff;
      pdd2_in        = pdd2_ff;
      d_in           = d_ff;
      dd_in          = dd_ff;
      xp_in          = xp_ff;
      num_in         = num_ff;
      nmag_in        = nmag_ff;
      nneg_in        = nneg_ff;
      rsp_valid_in   = 1'b0;
      rsp_degree_in  = rsp_degree_ff;
      rsp_poly_in    = rsp_poly_ff;
      rsp_d_in       = rsp_d_ff;
      rsp_dd_in      = rsp_dd_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_batch_in   = rsp_batch_ff;
      mac_ctrl       = '0;
      mac_a          = '0;
      mac_b          = '0;
      scl_base       = '0;
      scl_coef       = '0;
      scl_operand    = '0;

      // configuration writes; the user must issue them only while idle, the block does not enforce it
      if (csr_write_enable) begin
         unique case (lpde_pkg::csr_index_type'(csr_index))
            lpde_pkg::CSR_LOW_DEGREE:  low_degree_in  = csr_write_data;
            lpde_pkg::CSR_HIGH_DEGREE: high_degree_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         lpde_pkg::ST_IDLE: begin
            if (accept) begin
               // load P0 = 1, P-1 = 0 and all derivatives zero
               batch_in   = req_last_point;
               x_neg_in   = req_x_value[lpde_pkg::X_W-1];
               x_mag_in   = req_x_value[lpde_pkg::X_W-1] ? (~req_x_value + 1'b1) : req_x_value;
               pm1_in     = lpde_pkg::ONE_VALUE;
               pm1_mag_in = lpde_pkg::ONE_VALUE;
               pm1_neg_in = 1'b0;
               pm2_in     = '0;
               pd1_in     = '0;
               pd2_in     = '0;
               pdd1_in    = '0;
               pdd2_in    = '0;
               j_in       = {{(lpde_pkg::DEG_W-1){1'b0}}, 1'b1};
               // empty range: nothing to emit, stay idle
               if (low_degree_ff <= hi_eff) begin
                  if (low_degree_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_degree_in = '0;
                     rsp_poly_in   = lpde_pkg::ONE_VALUE;
                     rsp_d_in      = '0;
                     rsp_dd_in     = '0;
                     rsp_last_in   = (hi_eff == '0);
                     rsp_batch_in  = (hi_eff == '0) && req_last_point;
                  end
                  if (hi_eff != '0) begin
                     state_in = lpde_pkg::ST_XP0;
                  end
               end
            end
         end
         lpde_pkg::ST_XP0: begin
            // x * P(j-1), low column; P'(j) on the scaler
            mac_ctrl.issue = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_0;
            mac_a          = x_mag_ff;
            mac_b          = pm1_mag_ff[lpde_pkg::MUL_W-1:0];
            scl_base       = {{(lpde_pkg::NUM_W-lpde_pkg::VAL_W){pd2_ff[lpde_pkg::VAL_W-1]}},
                              pd2_ff};
            scl_coef       = coef_c;
            scl_operand    = pm1_ff;
            d_in           = lpde_pkg::sat_value(scl_sum);
            state_in       = lpde_pkg::ST_XP1;
         end
         lpde_pkg::ST_XP1: begin
            // x * P(j-1), high column; P''(j) on the scaler
            mac_ctrl.issue = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_32;
            mac_a          = x_mag_ff;
            mac_b          = {{(2*lpde_pkg::MUL_W-lpde_pkg::VAL_W){1'b0}},
                              pm1_mag_ff[lpde_pkg::VAL_W-1:lpde_pkg::MUL_W]};
            scl_base       = {{(lpde_pkg::NUM_W-lpde_pkg::VAL_W){pdd2_ff[lpde_pkg::VAL_W-1]}},
                              pdd2_ff};
            scl_coef       = coef_c;
            scl_operand    = pd1_ff;
            dd_in          = lpde_pkg::sat_value(scl_sum);
            state_in       = lpde_pkg::ST_XPW;
         end
         lpde_pkg::ST_XPW: begin
            // start the numerator with -(j-1) * P(j-2), unsaturated
            scl_coef    = coef_m;
            scl_operand = pm2_ff;
            num_in      = scl_sum[lpde_pkg::NUM_W-1:0];
            state_in    = lpde_pkg::ST_XPR;
         end
         lpde_pkg::ST_XPR: begin
            xp_in    = xp_neg ? -xp_mag : xp_mag;
            state_in = lpde_pkg::ST_NUM;
         end
         lpde_pkg::ST_NUM: begin
            // numerator += (2j-1) * xP
            scl_base    = num_ff;
            scl_coef    = coef_c;
            scl_operand = xp_ff;
            num_in      = scl_sum[lpde_pkg::NUM_W-1:0];
            state_in    = lpde_pkg::ST_NMAG;
         end
         lpde_pkg::ST_NMAG: begin
            nneg_in  = num_ff[lpde_pkg::NUM_W-1];
            nmag_in  = num_ff[lpde_pkg::NUM_W-1] ? -num_ff : num_ff;
            state_in = lpde_pkg::ST_P0;
         end
         lpde_pkg::ST_P0: begin
            // numerator times the reciprocal of j, four partial products
            mac_ctrl.issue = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_0;
            mac_a          = nmag_ff[lpde_pkg::MUL_W-1:0];
            mac_b          = recip[lpde_pkg::MUL_W-1:0];
            state_in       = lpde_pkg::ST_P1;
         end
         lpde_pkg::ST_P1: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_32;
            mac_a          = nmag_ff[lpde_pkg::MUL_W-1:0];
            mac_b          = {{(2*lpde_pkg::MUL_W-lpde_pkg::RECIP_W){1'b0}},
                              recip[lpde_pkg::RECIP_W-1:lpde_pkg::MUL_W]};
            state_in       = lpde_pkg::ST_P2;
         end
         lpde_pkg::ST_P2: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_32;
            mac_a          = {{(2*lpde_pkg::MUL_W-lpde_pkg::NUM_W){1'b0}},
                              nmag_ff[lpde_pkg::NUM_W-1:lpde_pkg::MUL_W]};
            mac_b          = recip[lpde_pkg::MUL_W-1:0];
            state_in       = lpde_pkg::ST_P3;
         end
         lpde_pkg::ST_P3: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.shift = lpde_pkg::SHIFT_64;
            mac_a          = {{(2*lpde_pkg::MUL_W-lpde_pkg::NUM_W){1'b0}},
                              nmag_ff[lpde_pkg::NUM_W-1:lpde_pkg::MUL_W]};
            mac_b          = {{(2*lpde_pkg::MUL_W-lpde_pkg::RECIP_W){1'b0}},
                              recip[lpde_pkg::RECIP_W-1:lpde_pkg::MUL_W]};
            state_in       = lpde_pkg::ST_PW;
         end
         lpde_pkg::ST_PW: begin
            // last partial product lands in the accumulator
            state_in = lpde_pkg::ST_PR;
         end
         lpde_pkg::ST_PR: begin
            // shift the recurrence and emit degree j if it is in range
            pm2_in     = pm1_ff;
            pm1_in     = p_val;
            pm1_mag_in = p_mag;
            pm1_neg_in = nneg_ff && (p_mag != '0);
            pd2_in     = pd1_ff;
            pd1_in     = d_ff;
            pdd2_in    = pdd1_ff;
            pdd1_in    = dd_ff;
            if (j_ff >= low_degree_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_degree_in = j_ff;
               rsp_poly_in   = p_val;
               rsp_d_in      = d_ff;
               rsp_dd_in     = dd_ff;
               rsp_last_in   = (j_ff == hi_eff);
               rsp_batch_in  = (j_ff == hi_eff) && batch_ff;
            end
            if (j_ff == hi_eff) begin
               state_in = lpde_pkg::ST_IDLE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = lpde_pkg::ST_XP0;
            end
         end
         default: state_in = lpde_pkg::ST_IDLE;
      endcase
   end

   assign busy             = (state_ff != lpde_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_degree_out   = rsp_degree_ff;
   assign rsp_poly_value   = rsp_poly_ff;
   assign rsp_first_deriv  = rsp_d_ff;
   assign rsp_second_deriv = rsp_dd_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_batch_end    = rsp_batch_ff;

`ifndef SYNTHESIS
   // an empty degree range finishes at once with no transaction
   a_empty_range: assert property (@(posedge clock) disable iff (reset)
      (accept && (low_degree_ff > hi_eff)) |=> (!busy && !rsp_valid))
      else $error("empty degree range produced a result or kept the block busy");

   // the closing transaction of a run leaves the block idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> !busy)
      else $error("block still busy after the last result of a run");

   // any other transaction comes while the run is still going
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> busy)
      else $error("intermediate result while the sequencer is idle");
`endif

endmodule

### test/legendre_result_checker.sv
module legendre_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [lpde_pkg::X_W-1:0]     req_x_value,
   input  logic                                req_last_point,
   input  logic                                rsp_valid,
   input  logic [lpde_pkg::DEG_W-1:0]          rsp_degree_out,
   input  logic signed [lpde_pkg::VAL_W-1:0]   rsp_poly_value,
   input  logic signed [lpde_pkg::VAL_W-1:0]   rsp_first_deriv,
   input  logic signed [lpde_pkg::VAL_W-1:0]   rsp_second_deriv,
   input  logic                                rsp_last_of_run,
   input  logic                                rsp_batch_end,
   input  logic                                csr_write_enable,
   input  logic [lpde_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpde_pkg::DEG_W-1:0]          csr_write_data,
   output int                                  fail_count,
   output int                                  open_results,
   output int                                  results_checked,
   output int                                  points_taken
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_MAX = (longint'(1) <<< 47) - 1;
   localparam longint Q_MIN = -Q_MAX - 1;
   localparam longint Q_ONE = longint'(1) <<< 32;

   typedef struct packed {
      logic [lpde_pkg::DEG_W-1:0] degree;
      logic [lpde_pkg::VAL_W-1:0] value;
      logic [lpde_pkg::VAL_W-1:0] slope;
      logic [lpde_pkg::VAL_W-1:0] curvature;
      logic                       last_of_run;
      logic                       batch_end;
   } legendre_result_type;

   legendre_result_type awaited_results[$];
   legendre_result_type oldest;
   logic [lpde_pkg::DEG_W-1:0] low_reg;
   logic [lpde_pkg::DEG_W-1:0] high_reg;

   initial begin
      fail_count      = 0;
      open_results    = 0;
      results_checked = 0;
      points_taken    = 0;
      low_reg         = '0;
      high_reg        = 4'd15;
   end

   function automatic longint clamp48(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // product of magnitudes, rounded half up, shifted and clamped, sign restored
   function automatic longint mul_round(input longint a, input longint b, input int sh);
      logic         neg;
      logic [127:0] mag_a;
      logic [127:0] mag_b;
      logic [127:0] q;
      logic [127:0] lim;
      neg   = (a < 0) != (b < 0);
      mag_a = {64'd0, ((a < 0) ? -a : a)};
      mag_b = {64'd0, ((b < 0) ? -b : b)};
      q     = (mag_a * mag_b + (128'd1 << (sh - 1))) >> sh;
      lim   = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint reciprocal(input int j);
      return longint'(((64'd1 << 40) + 64'(j / 2)) / 64'(j));
   endfunction

   function automatic void add_expected(input int deg, input longint p, input longint d,
                                        input longint dd, input logic last, input logic batch);
      legendre_result_type r;
      r.degree      = lpde_pkg::DEG_W'(deg);
      r.value       = p[lpde_pkg::VAL_W-1:0];
      r.slope       = d[lpde_pkg::VAL_W-1:0];
      r.curvature   = dd[lpde_pkg::VAL_W-1:0];
      r.last_of_run = last;
      r.batch_end   = last & batch;
      awaited_results.push_back(r);
   endfunction

   // three-term recurrence with derivatives, one expected result per emitted degree
   function automatic void predict_run(input logic signed [lpde_pkg::X_W-1:0] x_in,
                                       input logic batch);
      longint x;
      longint p_prev2, p_prev1, d_prev2, d_prev1, dd_prev2, dd_prev1;
      longint c, xp, num, p, d, dd;
      int     top;
      x   = longint'(x_in);
      top = (int'(high_reg) > lpde_pkg::MAX_DEGREE) ? lpde_pkg::MAX_DEGREE : int'(high_reg);
      if (int'(low_reg) > top) return;
      p_prev2  = 0;
      p_prev1  = Q_ONE;
      d_prev2  = 0;
      d_prev1  = 0;
      dd_prev2 = 0;
      dd_prev1 = 0;
      if (low_reg == 0) add_expected(0, p_prev1, longint'(0), longint'(0), top == 0, batch);
      for (int j = 1; j <= top; j++) begin
         c        = longint'(2 * j - 1);
         xp       = mul_round(x, p_prev1, lpde_pkg::XP_SHIFT);
         num      = c * xp - longint'(j - 1) * p_prev2;
         p        = mul_round(num, reciprocal(j), lpde_pkg::RECIP_SHIFT);
         d        = clamp48(d_prev2 + c * p_prev1);
         dd       = clamp48(dd_prev2 + c * d_prev1);
         p_prev2  = p_prev1;
         p_prev1  = p;
         d_prev2  = d_prev1;
         d_prev1  = d;
         dd_prev2 = dd_prev1;
         dd_prev1 = dd;
         if (j >= int'(low_reg)) add_expected(j, p, d, dd, j == top, batch);
      end
   endfunction

   function automatic void check_field(input string name, input logic [lpde_pkg::DEG_W-1:0] deg,
                                       input logic [lpde_pkg::VAL_W-1:0] want,
                                       input logic [lpde_pkg::VAL_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: degree %0d %s expected %h got %h", $time, deg, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         low_reg  = '0;
         high_reg = 4'd15;
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected, degree %0d", $time, rsp_degree_out);
            end else begin
               oldest = awaited_results.pop_front();
               results_checked++;
               check_field("degree", oldest.degree, lpde_pkg::VAL_W'(oldest.degree),
                           lpde_pkg::VAL_W'(rsp_degree_out));
               check_field("poly_value", oldest.degree, oldest.value, rsp_poly_value);
               check_field("first_deriv", oldest.degree, oldest.slope, rsp_first_deriv);
               check_field("second_deriv", oldest.degree, oldest.curvature, rsp_second_deriv);
               check_field("last_of_run", oldest.degree, lpde_pkg::VAL_W'(oldest.last_of_run),
                           lpde_pkg::VAL_W'(rsp_last_of_run));
               check_field("batch_end", oldest.degree, lpde_pkg::VAL_W'(oldest.batch_end),
                           lpde_pkg::VAL_W'(rsp_batch_end));
            end
         end
         // a point taken at this edge still sees the degree range from before the write
         if (start && !busy) begin
            points_taken++;
            predict_run(req_x_value, req_last_point);
         end
         if (csr_write_enable) begin
            if (csr_index == lpde_pkg::CSR_LOW_DEGREE) low_reg = csr_write_data;
            else if (csr_index == lpde_pkg::CSR_HIGH_DEGREE) high_reg = csr_write_data;
         end
      end
      open_results = awaited_results.size();
   end

endmodule

### test/tb_legendre_poly_deriv_eval.sv
module tb_legendre_poly_deriv_eval;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   // one pass of the shared multiplier for every degree of the longest run, plus a margin
   localparam int SETTLE_CYCLES = 12 * lpde_pkg::MAX_DEGREE + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_POINTS = 312;
   localparam logic [lpde_pkg::X_W-1:0] X_ONE = 32'h4000_0000;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               start            = 1'b0;
   logic                               busy;
   logic signed [lpde_pkg::X_W-1:0]    req_x_value      = '0;
   logic                               req_last_point   = 1'b0;
   logic                               rsp_valid;
   logic [lpde_pkg::DEG_W-1:0]         rsp_degree_out;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_poly_value;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_first_deriv;
   logic signed [lpde_pkg::VAL_W-1:0]  rsp_second_deriv;
   logic                               rsp_last_of_run;
   logic                               rsp_batch_end;
   logic                               csr_write_enable = 1'b0;
   logic [lpde_pkg::CSR_IDX_W-1:0]     csr_index        = '0;
   logic [lpde_pkg::DEG_W-1:0]         csr_write_data   = '0;

   int fail_count;
   int open_results;
   int results_checked;
   int points_taken;
   int cycle_count      = 0;
   int settings_written = 0;
   int sender_idle_pct  = 0;

   // corner points: +1, -1, 0, +-0.5, one lsb either side of zero,
   // both ends of the 32-bit range (outside [-1,1], saturating) and just under +1
   logic [lpde_pkg::X_W-1:0] corner_points [10] = '{
      32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 32'h2000_0000, 32'hE000_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF
   };

   // directed degree ranges: single degree at each end, low above high,
   // fully inverted range, a middle window and the two lowest degrees
   logic [lpde_pkg::DEG_W-1:0] corner_lo [6] = '{4'd0, 4'd15, 4'd9, 4'd15, 4'd3, 4'd0};
   logic [lpde_pkg::DEG_W-1:0] corner_hi [6] = '{4'd0, 4'd15, 4'd4, 4'd0, 4'd7, 4'd1};

   int phase_idle [3] = '{14, 82, 0};

   legendre_poly_deriv_eval u_dut (.*);

   legendre_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_value      (req_x_value),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_degree_out   (rsp_degree_out),
      .rsp_poly_value   (rsp_poly_value),
      .rsp_first_deriv  (rsp_first_deriv),
      .rsp_second_deriv (rsp_second_deriv),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_batch_end    (rsp_batch_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .open_results     (open_results),
      .results_checked  (results_checked),
      .points_taken     (points_taken)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog: the slowest correct run stays far below this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, open_results);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // mostly inside [-1,1], some corners, some anywhere in the 32-bit range
   function automatic logic [lpde_pkg::X_W-1:0] draw_point();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom();
      if (pick < 14) return corner_points[$urandom_range(9)];
      return lpde_pkg::X_W'($urandom_range(32'h8000_0000, 0)) - X_ONE;
   endfunction

   // one transaction on the command side; called and returning at a falling edge,
   // start is left high so back-to-back points need no gap
   task automatic send_point(input logic [lpde_pkg::X_W-1:0] x, input logic last);
      logic taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         start          <= 1'b0;
         req_x_value    <= $urandom();
         req_last_point <= 1'($urandom_range(1));
         @(negedge clock);
      end
      start          <= 1'b1;
      req_x_value    <= x;
      req_last_point <= last;
      // busy only moves at the rising edge, so its value here holds through the next edge
      do begin
         taken = !busy;
         @(negedge clock);
      end while (!taken);
   endtask

   // both registers, back to back, only while the block is idle
   task automatic write_degrees(input logic [lpde_pkg::DEG_W-1:0] lo,
                                input logic [lpde_pkg::DEG_W-1:0] hi);
      csr_write_enable <= 1'b1;
      csr_index        <= lpde_pkg::CSR_LOW_DEGREE;
      csr_write_data   <= lo;
      @(negedge clock);
      csr_index        <= lpde_pkg::CSR_HIGH_DEGREE;
      csr_write_data   <= hi;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   // drop start, drain all expected results, then let a run with no output finish
   task automatic settle();
      start <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly an ordered window, sometimes the full range, a single top degree or low above high
   task automatic choose_degrees(output logic [lpde_pkg::DEG_W-1:0] lo,
                                 output logic [lpde_pkg::DEG_W-1:0] hi);
      int unsigned pick;
      pick = $urandom_range(15);
      if (pick == 0) begin
         lo = 4'd0;
         hi = 4'd15;
      end else if (pick == 1) begin
         lo = 4'd15;
         hi = 4'd15;
      end else if (pick == 2) begin
         hi = lpde_pkg::DEG_W'($urandom_range(14));
         lo = lpde_pkg::DEG_W'($urandom_range(15, hi + 1));
      end else begin
         hi = lpde_pkg::DEG_W'($urandom_range(15));
         lo = lpde_pkg::DEG_W'($urandom_range(hi));
      end
   endtask

   initial begin
      logic [lpde_pkg::DEG_W-1:0] lo;
      logic [lpde_pkg::DEG_W-1:0] hi;
      int                         pick;
      int                         sent;
      int                         run_len;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: every corner point over the full range
      write_degrees(4'd0, 4'd15);
      foreach (corner_points[i]) send_point(corner_points[i], i[0]);
      settle();

      // directed part: degree-range extremes with a couple of corner points each
      pick = 0;
      foreach (corner_lo[k]) begin
         write_degrees(corner_lo[k], corner_hi[k]);
         repeat (2) begin
            send_point(corner_points[pick], pick[0]);
            pick = (pick + 3) % 10;
         end
         settle();
      end

      // random part: three sender idle profiles, new degree range every few points
      foreach (phase_idle[p]) begin
         sender_idle_pct = phase_idle[p];
         sent = 0;
         while (sent < RANDOM_POINTS / 3) begin
            choose_degrees(lo, hi);
            write_degrees(lo, hi);
            run_len = $urandom_range(18, 8);
            repeat (run_len) begin
               send_point(draw_point(), 1'($urandom_range(1)));
               sent++;
            end
            settle();
         end
      end

      $display("covered %0d points under %0d degree-range settings, %0d results compared",
               points_taken, settings_written, results_checked);
      $display("corner points, inverted ranges and sender idle rates of 14, 82 and 0 percent");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
